[sv/lpr_pkg.sv]
// Shared types and constants for the LRU page replacement core.
// No dependencies; every other file imports this package.
package lpr_pkg;

	// Fixed field widths of the channels and the configuration register
	localparam int PAGE_NUM_W  = 16;
	localparam int FRAME_IDX_W = 3;
	localparam int FAULT_CNT_W = 16;
	localparam int CFG_W       = 4;

	localparam logic [CFG_W-1:0]       CFG_RESET = 4'd8;
	localparam logic [FAULT_CNT_W-1:0] FAULT_MAX = 16'hFFFF;

	// Controller to datapath commands
	typedef struct packed {
		logic start;    // input transfer, clear the search results
		logic scan_rd;  // read one frame and step the scan index
		logic commit;   // apply the update and load the result register
	} lpr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;  // scan index sits on the last active frame
	} lpr_sts_t;

endpackage

[sv/lpr_in_if.sv]
// Page reference channel: valid/ready handshake with the page number.
// Depends on lpr_pkg.
interface lpr_in_if import lpr_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [PAGE_NUM_W-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink (input valid, input page_number, output ready);

endinterface

[sv/lpr_out_if.sv]
// Result channel: valid/ready handshake with the replacement outcome.
// Depends on lpr_pkg.
interface lpr_out_if import lpr_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic                   fault_flag;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic                   evicted_valid;
	logic [PAGE_NUM_W-1:0]  evicted_page;
	logic [FAULT_CNT_W-1:0] fault_count;

	modport source (output valid, output fault_flag, output frame_index,
		output evicted_valid, output evicted_page, output fault_count, input ready);
	modport sink (input valid, input fault_flag, input frame_index,
		input evicted_valid, input evicted_page, input fault_count, output ready);

endinterface

[sv/lpr_ctrl.sv]
// Sequencing state machine of the LRU page replacement core.
// Depends on lpr_pkg; drives lpr_dpath through lpr_cmd_t.
module lpr_ctrl import lpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lpr_sts_t sts,
	output lpr_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// Result register can take a new result this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A transfer always starts a scan
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_SCAN))
		else $error("accepted reference did not start a scan");

	// A pending update waits while the result register is still full
	a_update_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && !out_free) |=> (state_q == S_UPDATE && out_valid_q))
		else $error("update left while result register was occupied");

endmodule

[sv/lpr_dpath.sv]
// Datapath of the LRU page replacement core: page memory, valid bits,
// recency ranks, frame scan, fault counter and result register. Depends on lpr_pkg.
module lpr_dpath import lpr_pkg::*; #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpr_cmd_t               cmd,
	output lpr_sts_t               sts,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic [PAGE_NUM_W-1:0]  in_page,
	output logic                   fault_flag,
	output logic [FRAME_IDX_W-1:0] frame_index,
	output logic                   evicted_valid,
	output logic [PAGE_NUM_W-1:0]  evicted_page,
	output logic [FAULT_CNT_W-1:0] fault_count
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;
	localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

	// Frame contents
	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [IW-1:0]        rank_q [FRAMES];

	logic [CFG_W-1:0]       frames_in_use_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic [FAULT_CNT_W-1:0] fault_q;
	logic [FAULT_CNT_W-1:0] fault_d;

	// Scan and search results
	logic [IW-1:0]        scan_idx_q;
	logic                 eval_vld_s1;
	logic [IW-1:0]        eval_idx_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic                 hit_q;
	logic [IW-1:0]        hit_idx_q;
	logic                 empty_q;
	logic [IW-1:0]        empty_idx_q;
	logic [IW-1:0]        best_q;
	logic [IW-1:0]        vic_idx_q;
	logic [PAGE_BITS-1:0] vic_page_q;

	logic [CW-1:0] fiu_ext;
	logic [CW-1:0] n_act;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] slot;
	logic [IW-1:0] age_lim;
	logic          evict;
	logic          eval_valid;
	logic [IW-1:0] eval_rank;

	// Active frame count, clamped to 1..FRAMES
	assign fiu_ext = CW'(frames_in_use_q);
	always_comb begin
		if (fiu_ext == '0) begin
			n_act = CW'(1);
		end else if (fiu_ext > CW'(FRAMES)) begin
			n_act = CW'(FRAMES);
		end else begin
			n_act = fiu_ext;
		end
	end
	assign last_idx      = IW'(n_act - CW'(1));
	assign sts.scan_last = (scan_idx_q == last_idx);

	// Frame chosen for this reference and the rank bound for ageing
	assign evict   = !hit_q && !empty_q;
	assign slot    = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : vic_idx_q);
	assign age_lim = hit_q ? rank_q[slot] : RANK_MAX;
	assign fault_d = (!hit_q && fault_q != FAULT_MAX) ? fault_q + 1'b1 : fault_q;

	assign eval_valid = valid_q[eval_idx_s1];
	assign eval_rank  = rank_q[eval_idx_s1];

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg_we) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	// Page memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q) begin
			page_mem[slot] <= page_q;
		end
		if (cmd.scan_rd) begin
			rd_page_s1 <= page_mem[scan_idx_q];
		end
	end

	// Scan index and evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			eval_vld_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd && !sts.scan_last) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= PAGE_BITS'(in_page);
		end
		if (cmd.scan_rd) begin
			eval_idx_s1 <= scan_idx_q;
		end
	end

	// Search flags: first hit, first empty frame, largest rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			best_q  <= '0;
		end else if (cmd.start) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			best_q  <= '0;
		end else if (eval_vld_s1) begin
			if (!hit_q && eval_valid && rd_page_s1 == page_q) begin
				hit_q <= 1'b1;
			end
			if (!empty_q && !eval_valid) begin
				empty_q <= 1'b1;
			end
			if (eval_rank > best_q) begin
				best_q <= eval_rank;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_vld_s1) begin
			if (!hit_q && eval_valid && rd_page_s1 == page_q) begin
				hit_idx_q <= eval_idx_s1;
			end
			if (!empty_q && !eval_valid) begin
				empty_idx_q <= eval_idx_s1;
			end
			// frame 0 is the victim unless a larger rank turns up
			if (eval_idx_s1 == '0 || eval_rank > best_q) begin
				vic_idx_q  <= eval_idx_s1;
				vic_page_q <= rd_page_s1;
			end
		end
	end

	// Recency ranks, valid bits and fault total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fault_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			fault_q <= fault_d;
			for (int i = 0; i < FRAMES; i++) begin
				if (IW'(i) == slot) begin
					rank_q[i]  <= '0;
					valid_q[i] <= 1'b1;
				end else if (IW'(i) <= last_idx && valid_q[i] && rank_q[i] < age_lim) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			fault_flag    <= !hit_q;
			frame_index   <= FRAME_IDX_W'(slot);
			evicted_valid <= evict;
			evicted_page  <= evict ? PAGE_NUM_W'(vic_page_q) : '0;
			fault_count   <= fault_d;
		end
	end

	// The scan never looks past the active frames
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		eval_vld_s1 |-> (eval_idx_s1 <= last_idx))
		else $error("scan evaluated an inactive frame");

	// The frame just referenced becomes most recent and valid
	a_slot_recent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (rank_q[$past(slot)] == '0 && valid_q[$past(slot)]))
		else $error("referenced frame not made most recent");

	// The fault total never decreases
	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (fault_q >= $past(fault_q)))
		else $error("fault total went down");

endmodule

[sv/lru_page_replacement_core.sv]
// LRU page replacement core: one page reference in, one result out, with a
// controller (lpr_ctrl) and datapath (lpr_dpath). Depends on lpr_pkg, lpr_in_if, lpr_out_if.
//
// Keeps FRAMES fully associative page frames in least-recently-used order.
// Each reference scans the N active frames in turn, where N is
// the active frame count (frames_in_use clamped to 1..FRAMES): the scan reads
// one frame per cycle through the single read port of the page memory, then
// the drain state empties the read pipeline and the update state applies the update. The result
// sits in an output register, so a new reference is taken while the previous
// result still waits; the update stalls only if that register is still full.
// frames_in_use (cfg_wdata, 4 bits) is written when cfg_we is high and must
// only change while no reference is in flight. Frames above the active count
// keep their contents and come back into view if the count grows again.
module lru_page_replacement_core import lpr_pkg::*; #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	lpr_in_if.sink           page_in,
	lpr_out_if.source        result_out
);

	lpr_cmd_t cmd;
	lpr_sts_t sts;

	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (page_in.valid),
		.in_ready  (page_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpr_dpath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_page       (page_in.page_number),
		.fault_flag    (result_out.fault_flag),
		.frame_index   (result_out.frame_index),
		.evicted_valid (result_out.evicted_valid),
		.evicted_page  (result_out.evicted_page),
		.fault_count   (result_out.fault_count)
	);

endmodule
